>>> src/sha256_stream_hasher_assert.svh
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// same-cycle implication
`define SHS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SHS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Types, constants and round functions shared by the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_FINISH = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // block source: full message block, first padded block, length-only block
  typedef enum logic [1:0] {
    MODE_FULL = 2'd0,
    MODE_PADA = 2'd1,
    MODE_PADB = 2'd2
  } blk_mode_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_LOAD  = 3'd1,
    S_ROUND = 3'd2,
    S_FINAL = 3'd3,
    S_EMIT  = 3'd4
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_t;

  typedef struct packed {
    logic      wr_byte;
    logic      clear;
    logic      load;
    logic      round;
    logic      final_add;
    blk_mode_t mode;
    logic [5:0] round_idx;
    logic [2:0] word_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] count;
  } dp_status_t;

  localparam logic [5:0] LAST_BYTE  = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [2:0] LAST_WORD  = 3'd7;
  localparam logic [7:0] PAD_MARK   = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

>>> src/shs_datapath.sv
// ----------------------------------------------------------------------------
// shs_datapath
// Block buffer, byte counters, message schedule, round unit and hash state.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  shs_pkg::dp_cmd_t       cmd,
  input  logic [7:0]             data_byte,
  output shs_pkg::dp_status_t    status,
  output logic [31:0]            digest_word
);

  logic [31:0] bufw  [16];
  logic [31:0] w     [16];
  logic [31:0] pad_w [16];
  logic [31:0] wv    [8];
  logic [31:0] chain [8];
  logic [31:0] fin   [8];
  logic [31:0] src   [8];
  logic [5:0]  count;
  logic [60:0] total;
  logic [63:0] bit_len;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;

  assign bit_len     = {total, 3'b000};
  assign status      = '{count: count};
  assign digest_word = fin[cmd.word_idx];

  // length-only block chains off the first finish block
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      src[i] = (cmd.mode == shs_pkg::MODE_PADB) ? fin[i] : chain[i];
    end
  end

  always_comb begin
    logic [7:0] src_byte;
    logic [7:0] len_byte;
    logic [7:0] pb;
    for (int p = 0; p < 64; p++) begin
      src_byte = bufw[p >> 2][(3 - (p & 3)) * 8 +: 8];
      len_byte = 8'(bit_len >> ((63 - p) * 8));
      pb       = 8'h00;
      case (cmd.mode)
        shs_pkg::MODE_FULL: pb = src_byte;
        shs_pkg::MODE_PADA: begin
          if (6'(p) < count) pb = src_byte;
          else if (6'(p) == count) pb = shs_pkg::PAD_MARK;
          else if (6'(p) >= shs_pkg::LEN_POS && count < shs_pkg::LEN_POS) pb = len_byte;
        end
        shs_pkg::MODE_PADB: begin
          if (6'(p) >= shs_pkg::LEN_POS) pb = len_byte;
        end
        default: pb = 8'h00;
      endcase
      pad_w[p >> 2][(3 - (p & 3)) * 8 +: 8] = pb;
    end
  end

  always_comb begin
    t1 = wv[7] + shs_pkg::big_s1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
       + shs_pkg::round_k(cmd.round_idx) + w[0];
    t2 = shs_pkg::big_s0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
    w_new = shs_pkg::small_s1(w[14]) + w[9] + shs_pkg::small_s0(w[1]) + w[0];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      bufw[count[5:2]][{~count[1:0], 3'b000} +: 8] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) chain[i] <= shs_pkg::init_h(3'(i));
      count <= '0;
      total <= '0;
    end else begin
      if (cmd.clear) begin
        for (int i = 0; i < 8; i++) chain[i] <= shs_pkg::init_h(3'(i));
        count <= '0;
        total <= '0;
      end
      if (cmd.wr_byte) begin
        count <= count + 6'd1;
        total <= total + 61'd1;
      end
      if (cmd.final_add && cmd.mode == shs_pkg::MODE_FULL) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + wv[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w  <= pad_w;
      wv <= src;
    end else if (cmd.round) begin
      wv[0] <= t1 + t2;
      wv[1] <= wv[0];
      wv[2] <= wv[1];
      wv[3] <= wv[2];
      wv[4] <= wv[3] + t1;
      wv[5] <= wv[4];
      wv[6] <= wv[5];
      wv[7] <= wv[6];
      for (int j = 0; j < 15; j++) w[j] <= w[j + 1];
      w[15] <= w_new;
    end
    if (cmd.final_add && cmd.mode != shs_pkg::MODE_FULL) begin
      for (int i = 0; i < 8; i++) fin[i] <= src[i] + wv[i];
    end
  end

endmodule

`default_nettype wire

>>> src/shs_ctrl.sv
// ----------------------------------------------------------------------------
// shs_ctrl
// Sequencer: request decode, block load, 64 rounds, final add, digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic [1:0]          operation,
  output logic                item_stall,
  output logic                digest_valid,
  input  logic                digest_stall,
  input  shs_pkg::dp_status_t status,
  output shs_pkg::dp_cmd_t    cmd
);

  shs_pkg::state_t    state;
  shs_pkg::state_t    state_next;
  shs_pkg::blk_mode_t mode;
  logic               two_blk;
  logic [5:0]         round_cnt;
  logic [2:0]         word_cnt;
  logic               accept;
  logic               out_take;

  assign accept   = item_valid && (state == shs_pkg::S_IDLE);
  assign out_take = (state == shs_pkg::S_EMIT) && !digest_stall;

  always_comb begin
    state_next = state;
    case (state)
      shs_pkg::S_IDLE: begin
        if (accept) begin
          if (operation == shs_pkg::OP_FINISH) state_next = shs_pkg::S_LOAD;
          else if (operation == shs_pkg::OP_APPEND && status.count == shs_pkg::LAST_BYTE)
            state_next = shs_pkg::S_LOAD;
        end
      end
      shs_pkg::S_LOAD:  state_next = shs_pkg::S_ROUND;
      shs_pkg::S_ROUND: begin
        if (round_cnt == shs_pkg::LAST_ROUND) state_next = shs_pkg::S_FINAL;
      end
      shs_pkg::S_FINAL: begin
        if (mode == shs_pkg::MODE_PADA && two_blk) state_next = shs_pkg::S_LOAD;
        else if (mode == shs_pkg::MODE_FULL) state_next = shs_pkg::S_IDLE;
        else state_next = shs_pkg::S_EMIT;
      end
      shs_pkg::S_EMIT: begin
        if (out_take && word_cnt == shs_pkg::LAST_WORD) state_next = shs_pkg::S_IDLE;
      end
      default: state_next = shs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item_stall    = (state != shs_pkg::S_IDLE);
    digest_valid  = (state == shs_pkg::S_EMIT);
    cmd.wr_byte   = accept && (operation == shs_pkg::OP_APPEND);
    cmd.clear     = accept && (operation == shs_pkg::OP_CLEAR);
    cmd.load      = (state == shs_pkg::S_LOAD);
    cmd.round     = (state == shs_pkg::S_ROUND);
    cmd.final_add = (state == shs_pkg::S_FINAL);
    cmd.mode      = mode;
    cmd.round_idx = round_cnt;
    cmd.word_idx  = word_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= shs_pkg::S_IDLE;
      mode      <= shs_pkg::MODE_FULL;
      two_blk   <= 1'b0;
      round_cnt <= '0;
      word_cnt  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        mode    <= (operation == shs_pkg::OP_FINISH) ? shs_pkg::MODE_PADA
                                                     : shs_pkg::MODE_FULL;
        // marker plus length do not fit behind 56 or more pending bytes
        two_blk <= (status.count >= shs_pkg::LEN_POS);
      end
      if (state == shs_pkg::S_FINAL && mode == shs_pkg::MODE_PADA && two_blk) begin
        mode <= shs_pkg::MODE_PADB;
      end
      if (state == shs_pkg::S_LOAD) round_cnt <= '0;
      else if (state == shs_pkg::S_ROUND) round_cnt <= round_cnt + 6'd1;
      if (state == shs_pkg::S_FINAL) word_cnt <= '0;
      else if (out_take) word_cnt <= word_cnt + 3'd1;
    end
  end

endmodule

`default_nettype wire

>>> src/sha256_stream_hasher.sv
// Append, clear and unused codes leave the hasher idle; an append that completes
// a 64-byte block stalls requests for the schedule load, 64 rounds at one per cycle
// and the chain add. Finish runs load, rounds and final add, twice when 56 or more
// bytes are pending, then eight digest words, one per cycle unless the sink stalls.
// Reset (rst, synchronous) loads H0..H7 and zeroes the byte counts; buffer is not cleared.
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Streaming SHA-256: byte append, padded finish with digest output, clear.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  shs_pkg::item_t   item,
  output logic             digest_valid,
  input  logic             digest_stall,
  output shs_pkg::digest_t digest
);

  shs_pkg::dp_cmd_t    cmd;
  shs_pkg::dp_status_t status;
  logic [31:0]         word;

  shs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .operation    (item.operation),
    .item_stall   (item_stall),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .status       (status),
    .cmd          (cmd)
  );

  shs_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (item.data_byte),
    .status      (status),
    .digest_word (word)
  );

  always_comb begin
    digest.digest_word = word;
    digest.word_index  = cmd.word_idx;
    digest.last_word   = (cmd.word_idx == shs_pkg::LAST_WORD);
  end

endmodule

`default_nettype wire

>>> src/shs_checker.sv
// ----------------------------------------------------------------------------
// shs_checker
// Port-level checks on the hasher's request and digest channels.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha256_stream_hasher_assert.svh"

module shs_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input shs_pkg::item_t   item,
  input logic             digest_valid,
  input logic             digest_stall,
  input shs_pkg::digest_t digest
);

  `SHS_ASSERT_NXT(a_in_hold, item_valid && item_stall, item_valid && $stable(item), "request changed while stalled")
  `SHS_ASSERT_NXT(a_out_hold, digest_valid && digest_stall, digest_valid && $stable(digest), "digest changed while stalled")
  `SHS_ASSERT_IMP(a_last_flag, digest_valid, digest.last_word == (digest.word_index == 3'd7), "last_word mismatch")
  `SHS_ASSERT_NXT(a_word_seq, digest_valid && !digest_stall && !digest.last_word, digest_valid && digest.word_index == $past(digest.word_index) + 3'd1, "digest words not contiguous")
  `SHS_ASSERT_IMP(a_busy_out, digest_valid, item_stall, "request taken during digest output")

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (.*);

`default_nettype wire
